>>> sv/assert_macros.svh
// Assertion shorthands shared by the RTL files.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define ASSERT_IMPL(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

>>> sv/rpn_pkg.sv
package rpn_pkg;

  localparam int Q_W       = 32;
  localparam int FRAC_W    = 16;
  localparam int INT_W     = 16;
  localparam int NUM_W     = 48;
  localparam int DIV_STEPS = 48;
  localparam int CNT_W     = 6;

  localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN64 = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_MOD     = 3'd5,
    OP_PRINT   = 3'd6,
    OP_UNKNOWN = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_EMPTY   = 3'd1,
    ERR_FULL    = 3'd2,
    ERR_ZERO    = 3'd3,
    ERR_UNKNOWN = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_B,
    S_GET_B,
    S_POP_A,
    S_GET_A,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WRITE,
    S_DONE
  } state_t;

  // Clamp a wide signed value to the Q16.16 range.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX64) begin
      r = Q_MAX;
    end else if (v < Q_MIN64) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // Integer part of a Q16.16 value, truncated toward zero.
  function automatic logic signed [INT_W-1:0] trunc_int(input logic signed [Q_W-1:0] q);
    logic signed [INT_W-1:0] hi;
    hi = q[Q_W-1:FRAC_W];
    if (q[Q_W-1] && (q[FRAC_W-1:0] != '0)) begin
      hi = hi + 16'sd1;
    end
    return hi;
  endfunction

endpackage

>>> sv/rpn_div.sv
`include "assert_macros.svh"

module rpn_div import rpn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [Q_W-1:0]   divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [Q_W-1:0]   remainder
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [Q_W-1:0]   dvs;
  logic [Q_W:0]     shifted;
  logic [Q_W:0]     diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {remainder, quotient[NUM_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[NUM_W-2:0], fits};
      remainder <= fits ? diff[Q_W-1:0] : shifted[Q_W-1:0];
    end
  end

  `ASSERT_IMPL(a_done_after_busy, done, $past(busy), "divider done without a run")
  `ASSERT_IMPL(a_rem_below_divisor, done, remainder < dvs, "remainder not below divisor")
  `ASSERT_IMPL(a_busy_count, busy, cnt != '0, "divider busy with spent count")

endmodule

>>> sv/rpn_stack_calculator.sv
// Per token: unknown goes straight to done; push writes the stack; print and
// zero-divisor div/mod pop one operand; add/sub pop two, execute and write; mul adds a
// multiply state and div/mod wait on the 48-step divider; an output stall holds done.
// One token at a time; the next input beat can share the edge of the result beat.
// Reset clears the stack pointer, sequencer and output valid; stack memory
// contents stay unknown and are never read before they are written.
`include "assert_macros.svh"

module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            op,
  input  logic signed [Q_W-1:0] operand,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [Q_W-1:0] shown_value,
  output logic                  shown,
  output logic [2:0]            error
);

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

  // Sequencer and stack pointer.
  state_t          state, state_next;
  op_t             op_r;
  logic [SP_W-1:0] sp;
  logic [SP_W-1:0] sp_dec;
  logic            hit;      // last pop found an entry
  err_t            err;      // first fault of the current token

  // Operands and result of the current token.
  logic signed [Q_W-1:0] a, b, res;
  logic signed [Q_W-1:0] aval, bval;
  logic signed [63:0]    prod;
  logic signed [63:0]    scaled;
  logic                  neg;
  logic signed [Q_W-1:0] show_val;
  logic                  show_r;
  logic                  zero_div;

  // Stack memory, one read and one write port, registered read data.
  logic [Q_W-1:0]    mem [STACK_DEPTH];
  logic [Q_W-1:0]    rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_rd, mem_wr;

  // Divider hookup.
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_dividend;
  logic [Q_W-1:0]   div_divisor;
  logic [NUM_W-1:0] div_q;
  logic [Q_W-1:0]   div_rem;

  logic out_load;

  // Local operand work for div and mod setup and result fixup.
  logic [Q_W-1:0]          a_mag, b_mag;
  logic signed [INT_W-1:0] ai, bi;
  logic [INT_W-1:0]        ai_mag, bi_mag;
  logic signed [Q_W-1:0]   div_res;
  logic signed [INT_W-1:0] mod_r;

  assign sp_dec  = sp - 1'b1;
  assign rd_addr = sp_dec[ADDR_W-1:0];
  assign wr_addr = sp[ADDR_W-1:0];

  // A popped value is 0 when the stack was empty.
  assign bval = hit ? $signed(rdata) : '0;
  assign aval = hit ? $signed(rdata) : '0;

  // Div refuses a zero divisor; mod refuses a divisor whose integer part is 0.
  always_comb begin
    zero_div = 1'b0;
    if (op_r == OP_DIV && bval == '0) begin
      zero_div = 1'b1;
    end
    if (op_r == OP_MOD && trunc_int(bval) == '0) begin
      zero_div = 1'b1;
    end
  end

  // Divider operands: magnitudes, sign handled around the unit.
  always_comb begin
    a_mag  = a[Q_W-1] ? (~a + 1'b1) : a;
    b_mag  = b[Q_W-1] ? (~b + 1'b1) : b;
    ai     = trunc_int(a);
    bi     = trunc_int(b);
    ai_mag = ai[INT_W-1] ? (~ai + 1'b1) : ai;
    bi_mag = bi[INT_W-1] ? (~bi + 1'b1) : bi;
    if (op_r == OP_MOD) begin
      div_dividend = NUM_W'(ai_mag);
      div_divisor  = Q_W'(bi_mag);
    end else begin
      div_dividend = {a_mag, {FRAC_W{1'b0}}};
      div_divisor  = b_mag;
    end
  end

  // Signed fixup and clamp of the divider result.
  always_comb begin
    if (neg) begin
      if (div_q > NUM_W'(48'h8000_0000)) begin
        div_res = Q_MIN;
      end else begin
        div_res = -$signed(div_q[Q_W-1:0]);
      end
    end else begin
      if (div_q > NUM_W'(48'h7FFF_FFFF)) begin
        div_res = Q_MAX;
      end else begin
        div_res = $signed(div_q[Q_W-1:0]);
      end
    end
    mod_r = neg ? -$signed(div_rem[INT_W-1:0]) : $signed(div_rem[INT_W-1:0]);
  end

  // Product scaled by 2^-16, truncated toward zero.
  always_comb begin
    scaled = prod >>> FRAC_W;
    if (prod[63] && (prod[FRAC_W-1:0] != '0)) begin
      scaled = scaled + 64'sd1;
    end
  end

  rpn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(op) == OP_PUSH) begin
            state_next = S_WRITE;
          end else if (op_t'(op) == OP_UNKNOWN) begin
            state_next = S_DONE;
          end else begin
            state_next = S_POP_B;
          end
        end
      end
      S_POP_B: state_next = S_GET_B;
      S_GET_B: begin
        if (op_r == OP_PRINT || zero_div) begin
          state_next = S_DONE;
        end else begin
          state_next = S_POP_A;
        end
      end
      S_POP_A: state_next = S_GET_A;
      S_GET_A: state_next = S_EXEC;
      S_EXEC: begin
        unique case (op_r)
          OP_MUL:         state_next = S_MUL;
          OP_DIV, OP_MOD: state_next = S_DIV;
          default:        state_next = S_WRITE;
        endcase
      end
      S_MUL: state_next = S_WRITE;
      S_DIV: begin
        if (div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs. Reads and writes of the stack never share a cycle,
  // so no forwarding path is needed.
  always_comb begin
    in_ready  = state == S_IDLE;
    mem_rd    = (state == S_POP_B || state == S_POP_A) && sp != '0;
    mem_wr    = state == S_WRITE && sp < SP_FULL;
    div_start = state == S_EXEC && (op_r == OP_DIV || op_r == OP_MOD);
    out_load  = state == S_DONE && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stack pointer and error tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp  <= '0;
      hit <= 1'b0;
      err <= ERR_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err <= (op_t'(op) == OP_UNKNOWN) ? ERR_UNKNOWN : ERR_NONE;
          end
        end
        S_POP_B, S_POP_A: begin
          hit <= sp != '0;
          if (sp != '0) begin
            sp <= sp_dec;
          end else if (err == ERR_NONE) begin
            err <= ERR_EMPTY;
          end
        end
        S_GET_B: begin
          if (zero_div && err == ERR_NONE) begin
            err <= ERR_ZERO;
          end
        end
        S_WRITE: begin
          if (sp < SP_FULL) begin
            sp <= sp + 1'b1;
          end else if (err == ERR_NONE) begin
            err <= ERR_FULL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r     <= op_t'(op);
          res      <= operand;
          show_val <= '0;
          show_r   <= 1'b0;
        end
      end
      S_GET_B: begin
        b <= bval;
        if (op_r == OP_PRINT) begin
          show_val <= bval;
          show_r   <= 1'b1;
        end
      end
      S_GET_A: a <= aval;
      S_EXEC: begin
        prod <= 64'(a) * 64'(b);
        neg  <= (op_r == OP_MOD) ? ai[INT_W-1] : (a[Q_W-1] ^ b[Q_W-1]);
        if (op_r == OP_ADD) begin
          res <= sat_q(64'(a) + 64'(b));
        end else if (op_r == OP_SUB) begin
          res <= sat_q(64'(a) - 64'(b));
        end
      end
      S_MUL: res <= sat_q(scaled);
      S_DIV: begin
        if (div_done) begin
          res <= (op_r == OP_MOD) ? {mod_r, {FRAC_W{1'b0}}} : div_res;
        end
      end
      default: begin
      end
    endcase
  end

  // Stack memory.
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_addr] <= res;
    end
    if (mem_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  // Output register: hold the result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      shown_value <= show_val;
      shown       <= show_r;
      error       <= err;
    end
  end

  `ASSERT_ALWAYS(a_sp_bound, sp <= SP_FULL, "stack pointer beyond depth")
  `ASSERT_IMPL(a_div_done_wait, div_done, state == S_DIV, "divider result while not waiting")
  `ASSERT_IMPL(a_print_err, out_valid && shown, error <= ERR_EMPTY, "print beat with bad error")
  `ASSERT_NEXT(a_write_grows, mem_wr, sp != '0, "stack empty after a push")

endmodule
